@@ design/linear_blend_skinning_macros.svh @@
// Assertion macros for the skinning block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef LINEAR_BLEND_SKINNING_MACROS_SVH
`define LINEAR_BLEND_SKINNING_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define LBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication.
`define LBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

@@ design/lbs_pkg.sv @@
// Package for the skinning block: types, command codes, status codes.
// No dependencies.
package lbs_pkg;
    localparam int unsigned MAT_WORDS = 12;
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_WEIGHT = 1'b1;
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_ERR = 2'd2;
    localparam logic [1:0] REG_BLEND_MODE  = 2'd0;
    localparam logic [1:0] REG_JOINT_COUNT = 2'd1;

    typedef struct packed {
        logic        cmd;
        logic [5:0]  joint;
        logic [3:0]  elem;
        logic signed [31:0] matrix_word;
        logic [16:0] weight;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] vec_w;
        logic        last;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [1:0]         status;
    } t_out;

    // Classified work handed from front to back.
    typedef struct packed {
        logic        wr;      // matrix word write
        logic        err;     // joint out of range
        logic        first;   // opens a vertex
        logic        last;
        logic        mode;    // 1 local
        logic [5:0]  joint;
        logic [3:0]  elem;
        logic signed [31:0] word;
        logic [16:0] weight;
        logic signed [31:0] v0;
        logic signed [31:0] v1;
        logic signed [31:0] v2;
        logic signed [31:0] v3;
    } t_job;

    localparam logic signed [47:0] LIM48_HI = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] LIM48_LO = -48'sh7FFF_FFFF_FFFF - 48'sd1;

    function automatic logic signed [47:0] sat48(input logic signed [49:0] s,
                                                 output logic f);
        f = 1'b0;
        if (s > 50'(LIM48_HI)) begin
            f = 1'b1;
            return LIM48_HI;
        end
        if (s < 50'(LIM48_LO)) begin
            f = 1'b1;
            return LIM48_LO;
        end
        return s[47:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] s,
                                                 output logic f);
        f = 1'b0;
        if (s > 66'sh7FFF_FFFF) begin
            f = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (s < -66'sh8000_0000) begin
            f = 1'b1;
            return -32'sh8000_0000;
        end
        return s[31:0];
    endfunction
endpackage

@@ design/lbs_if.sv @@
// Valid/ready channel interface carrying one payload type.
// Depends on lbs_pkg only through the payload type parameter.
interface lbs_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/lbs_front.sv @@
// Front end: accepts beats, range-checks joints, tags vertex start, queues jobs.
// Depends on lbs_pkg.
module lbs_front #(
    parameter int MAX_JOINTS = 64,
    parameter int QDEPTH     = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_mode,
    input  logic [6:0]     i_joint_count,
    input  logic           i_valid,
    output logic           o_ready,
    input  lbs_pkg::t_in   i_data,
    output logic           o_job_valid,
    input  logic           i_job_take,
    output lbs_pkg::t_job  o_job
);
    import lbs_pkg::*;
    localparam int AW = $clog2(QDEPTH);

    t_job          r_q [QDEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          r_first;
    logic          push;
    t_job          job;
    logic [8:0]    lim;

    always_comb begin
        lim = (9'(i_joint_count) < 9'(MAX_JOINTS)) ? 9'(i_joint_count) : 9'(MAX_JOINTS);
        job.wr     = (i_data.cmd == CMD_WRITE);
        job.err    = (9'(i_data.joint) >= lim);
        job.first  = r_first;
        job.last   = i_data.last;
        job.mode   = i_mode;
        job.joint  = i_data.joint;
        job.elem   = i_data.elem;
        job.word   = i_data.matrix_word;
        job.weight = i_data.weight;
        job.v0     = i_data.vec_x;
        job.v1     = i_data.vec_y;
        job.v2     = i_data.vec_z;
        job.v3     = i_data.vec_w;
    end

    assign o_ready     = (r_cnt != (AW+1)'(QDEPTH));
    assign push        = i_valid && o_ready;
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
            r_first <= 1'b1;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
                if (i_data.cmd == CMD_WEIGHT) begin
                    r_first <= i_data.last;
                end
            end
            if (i_job_take) begin
                r_rp <= (r_rp == AW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(i_job_take);
        end
    end

    `include "linear_blend_skinning_macros.svh"
    `LBS_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, push, r_cnt < (AW+1)'(QDEPTH))
    `LBS_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_job_take, r_cnt != '0)
    `LBS_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= (AW+1)'(QDEPTH))
endmodule

@@ design/lbs_back.sv @@
// Back end: matrix store, shared multiplier sequencer, accumulators, result register.
// Depends on lbs_pkg.
module lbs_back #(
    parameter int MAX_JOINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    output logic           o_job_take,
    input  lbs_pkg::t_job  i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output lbs_pkg::t_out  o_data
);
    import lbs_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_RD, S_MAC, S_FIN, S_FMUL, S_OUT} t_state;

    // One row (four words) per step; memory is a row-wide array.
    logic [127:0]      r_mem [MAX_JOINTS*3];
    logic [127:0]      r_row;
    t_state            r_st;
    t_job              r_job;
    logic [1:0]        r_r;           // row index
    logic signed [47:0] r_bm [12];
    logic signed [47:0] r_acc [3];
    logic              r_sat, r_err;
    logic signed [63:0] r_p [4];
    logic              r_pv;
    logic [1:0]        r_pr;
    logic              r_ov;
    t_out              r_out;
    logic signed [31:0] r_res [3];
    logic              r_osat;

    logic [$clog2(MAX_JOINTS*3)-1:0] wra, rda;
    logic signed [31:0] m [4];
    logic signed [31:0] vsel [4];
    logic signed [31:0] cm [4];
    logic              cf [4];
    logic signed [65:0] rsum;
    logic signed [47:0] s48 [4];
    logic              sf [4];
    logic signed [31:0] r32;
    logic              f32;
    logic signed [47:0] a48;
    logic              fa;
    logic signed [31:0] c32;
    logic              fc;

    assign wra = ($clog2(MAX_JOINTS*3))'(i_job.joint * 3 + 32'(i_job.elem[3:2]));
    assign rda = ($clog2(MAX_JOINTS*3))'(r_job.joint * 3 + 32'(r_r));
    assign o_valid = r_ov;
    assign o_data  = r_out;
    assign o_job_take = i_job_valid && (r_st == S_IDLE) &&
                        (i_job.wr || i_job.err ? !(i_job.last && !i_job.wr && r_ov) : 1'b1);

    always_comb begin
        vsel[0] = r_job.v0; vsel[1] = r_job.v1; vsel[2] = r_job.v2; vsel[3] = r_job.v3;
        for (int k = 0; k < 4; k++) begin
            m[k] = r_row[32*k +: 32];
            cm[k] = sat32(66'(r_bm[4*r_pr + k]), cf[k]);
        end
        rsum = '0;
        for (int k = 0; k < 4; k++) begin
            rsum = rsum + 66'(r_p[k] >>> FRAC_BITS);
            s48[k] = sat48(50'(r_bm[4*r_pr + k]) + 50'(r_p[k] >>> FRAC_BITS), sf[k]);
        end
        a48 = sat48(50'(r_acc[r_pr]) + 50'(rsum), fa);
        r32 = sat32(rsum, f32);
        c32 = sat32(66'(r_acc[r_pr]), fc);
    end

    always_ff @(posedge i_clk) begin
        if (o_job_take && i_job.wr && i_job.elem < 4'd12 &&
            32'(i_job.joint) < MAX_JOINTS) begin
            r_mem[wra][32*i_job.elem[1:0] +: 32] <= i_job.word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pv <= 1'b0;
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
            r_sat <= 1'b0;
            r_err <= 1'b0;
            for (int i = 0; i < 12; i++) r_bm[i] <= '0;
            for (int i = 0; i < 3; i++) r_acc[i] <= '0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (o_job_take && !i_job.wr) begin
                        r_job <= i_job;
                        r_r <= '0;
                        if (i_job.first) begin
                            for (int i = 0; i < 12; i++) r_bm[i] <= '0;
                            for (int i = 0; i < 3; i++) r_acc[i] <= '0;
                            r_sat <= 1'b0;
                            r_err <= i_job.err;
                        end else if (i_job.err) begin
                            r_err <= 1'b1;
                        end
                        if (i_job.err) begin
                            r_st <= i_job.last ? S_FIN : S_IDLE;
                        end else begin
                            r_st <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_row <= r_mem[rda];
                    r_st <= S_MAC;
                end
                S_MAC: begin
                    // form four products of the fetched row
                    for (int k = 0; k < 4; k++) begin
                        r_p[k] <= r_job.mode ? 64'(m[k]) * 64'(vsel[k])
                                             : 64'($signed({1'b0, r_job.weight})) * 64'(m[k]);
                    end
                    r_pr <= r_r;
                    r_pv <= 1'b1;
                    if (r_r == 2'd2) begin
                        r_st <= S_FIN;
                    end else begin
                        r_r <= r_r + 2'd1;
                        r_st <= S_RD;
                    end
                end
                S_FIN: begin
                    // wait for last product to settle, then finish or return
                    if (!r_pv) begin
                        if (!r_job.last) begin
                            r_st <= S_IDLE;
                        end else if (!r_ov) begin
                            r_pr <= '0;
                            r_st <= S_FMUL;
                        end
                    end
                end
                S_FMUL: begin
                    if (r_job.mode) begin
                        r_res[r_pr] <= c32;
                    end else begin
                        for (int k = 0; k < 4; k++) r_p[k] <= 64'(cm[k]) * 64'(vsel[k]);
                        for (int k = 0; k < 4; k++) if (cf[k]) r_sat <= 1'b1;
                    end
                    r_pv <= 1'b1;
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (!r_pv) begin
                        if (r_pr == 2'd2) begin
                            r_out.out_x <= r_err ? '0 : r_res[0];
                            r_out.out_y <= r_err ? '0 : r_res[1];
                            r_out.out_z <= r_err ? '0 : r_res[2];
                            r_out.status <= r_err ? ST_ERR : (r_sat ? ST_SAT : ST_OK);
                            r_ov <= 1'b1;
                            r_st <= S_IDLE;
                        end else begin
                            r_pr <= r_pr + 2'd1;
                            r_st <= S_FMUL;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
            // retire registered products
            if (r_pv) begin
                if (r_st == S_FIN) begin
                    if (r_job.mode) begin
                        r_acc[r_pr] <= a48;
                        if (fa) r_sat <= 1'b1;
                    end else begin
                        for (int k = 0; k < 4; k++) begin
                            r_bm[4*r_pr + k] <= s48[k];
                            if (sf[k]) r_sat <= 1'b1;
                        end
                    end
                end else if (r_st == S_OUT) begin
                    if (r_job.mode) begin
                        if (fc) r_sat <= 1'b1;
                    end else begin
                        r_res[r_pr] <= r32;
                        if (f32) r_sat <= 1'b1;
                    end
                end else if (r_job.mode) begin
                    r_acc[r_pr] <= a48;
                    if (fa) r_sat <= 1'b1;
                end else begin
                    for (int k = 0; k < 4; k++) begin
                        r_bm[4*r_pr + k] <= s48[k];
                        if (sf[k]) r_sat <= 1'b1;
                    end
                end
            end
        end
    end

    `include "linear_blend_skinning_macros.svh"
    `LBS_ASSERT_NXT(a_hold_out, i_clk, i_rst_n, r_ov && !i_ready, r_ov && $stable(r_out))
    `LBS_ASSERT_IMP(a_take_idle, i_clk, i_rst_n, o_job_take, r_st == S_IDLE)
    `LBS_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, r_ov && r_out.status == ST_ERR,
                    r_out.out_x == '0)
endmodule

@@ design/linear_blend_skinning.sv @@
// Top level of the skinning block: APB registers, front end, back end.
// Depends on lbs_pkg, lbs_if, lbs_front and lbs_back.
//
// Usage:
//   i_in carries input beats (matrix word writes and weight beats); o_out
//   carries one result beat per vertex, on the weight beat with last set.
//   Matrix writes land in a row-wide store. Each weight beat whose joint is
//   in range reads the joint's three rows through one memory port and runs
//   three passes of four multipliers: it is taken, goes through three
//   read/multiply pairs, and the last row's products are retired. The
//   closing beat then adds three transform passes before the result is
//   registered, once the output register is free.
//   A four-entry job queue sits between front and back, so until it fills,
//   beats keep being taken while the back end works or a result waits.
//   Reset clears the vertex state, sets blend_mode to 0 and joint_count to
//   64; the matrix store is not cleared and must be written before use.
//   When the receiver stalls, the result is held in its output register;
//   further closing beats are held back, an out-of-range one in the queue
//   and others before their transform passes, and never overwrite it.
//   Registers: blend_mode at 0x0, joint_count at 0x4. Write only when idle.
module linear_blend_skinning #(
    parameter int MAX_JOINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lbs_if.sink         i_in,
    lbs_if.source       o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lbs_pkg::*;

    logic       r_mode;
    logic [6:0] r_jcnt;
    logic       job_valid, job_take;
    t_job       job;

    assign pready = 1'b1;
    // register read mux
    always_comb begin
        unique case (paddr[2])
            1'b0:    prdata = {31'd0, r_mode};
            default: prdata = {25'd0, r_jcnt};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_jcnt <= 7'd64;
        end else if (psel && penable && pwrite) begin
            if (paddr[2:2] == REG_BLEND_MODE[0] && paddr[1:0] == 2'd0) r_mode <= pwdata[0];
            else if (paddr == {REG_JOINT_COUNT[0], 2'b00}) r_jcnt <= pwdata[6:0];
        end
    end

    lbs_front #(.MAX_JOINTS(MAX_JOINTS)) u_front (
        .i_clk, .i_rst_n,
        .i_mode(r_mode), .i_joint_count(r_jcnt),
        .i_valid(i_in.valid), .o_ready(i_in.ready), .i_data(i_in.data),
        .o_job_valid(job_valid), .i_job_take(job_take), .o_job(job)
    );

    lbs_back #(.MAX_JOINTS(MAX_JOINTS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(job_valid), .o_job_take(job_take), .i_job(job),
        .o_valid(o_out.valid), .i_ready(o_out.ready), .o_data(o_out.data)
    );
endmodule

@@ tb/testbench.sv @@
// Self-checking bench for linear_blend_skinning: matrix writes, vertex beats,
// register writes over APB. Depends on lbs_pkg, lbs_if and the block RTL.
module testbench;
    import lbs_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    lbs_if #(.T(t_in))  in_ch (i_clk);
    lbs_if #(.T(t_out)) out_ch (i_clk);

    linear_blend_skinning uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    localparam int NJ = 64;
    localparam int LIMIT_CYCLES = 1500000;

    // Predictor state, kept apart from the block.
    logic signed [31:0] mat_store [NJ*12];
    logic signed [47:0] blend_acc [12];
    logic signed [47:0] vert_acc [3];
    bit  vert_open_next, vert_err, vert_sat;
    bit  mode_local;
    int  joints_used;

    t_out expected_q[$];
    int   fail_count;
    int   cycle_count;
    bit   stall_rx;
    bit   in_held;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Abort on a runaway run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        fail_count++;
    endtask

    // Floor shift by the fraction width on a wide signed product.
    function automatic logic signed [79:0] fshift(input logic signed [79:0] p);
        return p >>> 16;
    endfunction

    function automatic logic signed [47:0] acc48(input logic signed [79:0] s);
        if (s > 80'sh7FFF_FFFF_FFFF) begin
            vert_sat = 1; return 48'sh7FFF_FFFF_FFFF;
        end
        if (s < -80'sh8000_0000_0000) begin
            vert_sat = 1; return -48'sh8000_0000_0000;
        end
        return s[47:0];
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [79:0] s);
        if (s > 80'sh7FFF_FFFF) begin
            vert_sat = 1; return 32'sh7FFF_FFFF;
        end
        if (s < -80'sh8000_0000) begin
            vert_sat = 1; return -32'sh8000_0000;
        end
        return s[31:0];
    endfunction

    // Work out the result (if any) that one accepted beat causes.
    function automatic void skin_predict(input t_in b);
        logic signed [79:0] vec [4];
        logic signed [79:0] s;
        logic signed [79:0] m;
        t_out r;
        int base;
        if (b.cmd == CMD_WRITE) begin
            if (b.elem < 12) begin
                mat_store[b.joint*12 + b.elem] = b.matrix_word;
            end
            return;
        end
        vec[0] = 80'(b.vec_x); vec[1] = 80'(b.vec_y);
        vec[2] = 80'(b.vec_z); vec[3] = 80'(b.vec_w);
        if (vert_open_next) begin
            foreach (blend_acc[k]) blend_acc[k] = '0;
            foreach (vert_acc[k]) vert_acc[k] = '0;
            vert_err = 0;
            vert_sat = 0;
        end
        vert_open_next = 0;
        base = b.joint * 12;
        if (b.joint >= joints_used) begin
            vert_err = 1;
        end else if (mode_local) begin
            for (int rw = 0; rw < 3; rw++) begin
                s = 0;
                for (int k = 0; k < 4; k++) begin
                    m = 80'(mat_store[base + rw*4 + k]);
                    s += fshift(m * vec[k]);
                end
                vert_acc[rw] = acc48(80'(vert_acc[rw]) + s);
            end
        end else begin
            for (int k = 0; k < 12; k++) begin
                m = 80'(mat_store[base + k]);
                blend_acc[k] = acc48(80'(blend_acc[k])
                                     + fshift(m * $signed({1'b0, b.weight})));
            end
        end
        if (!b.last) return;
        for (int rw = 0; rw < 3; rw++) begin
            logic signed [31:0] o;
            if (mode_local) begin
                o = clip32(80'(vert_acc[rw]));
            end else begin
                s = 0;
                for (int k = 0; k < 4; k++) begin
                    m = 80'(clip32(80'(blend_acc[rw*4 + k])));
                    s += fshift(m * vec[k]);
                end
                o = clip32(s);
            end
            if (rw == 0) r.out_x = o;
            else if (rw == 1) r.out_y = o;
            else r.out_z = o;
        end
        if (vert_err) begin
            r.status = ST_ERR;
            r.out_x = 0; r.out_y = 0; r.out_z = 0;
        end else begin
            r.status = vert_sat ? ST_SAT : ST_OK;
        end
        expected_q.push_back(r);
        vert_open_next = 1;
    endfunction

    // Random receiver stalls, mostly short, sometimes long, with calm stretches.
    initial begin
        int gap;
        out_ch.ready <= 1'b0;
        stall_rx = 0;
        @(posedge i_clk);
        forever begin
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            if (!stall_rx && $urandom_range(0, 3) != 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // Check each result beat against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            t_out g, w;
            g = out_ch.data;
            if (expected_q.size() == 0) begin
                report("unexpected result beat, status", g.status, 0);
            end else begin
                w = expected_q.pop_front();
                if (g.out_x !== w.out_x) report("out_x", g.out_x, w.out_x);
                if (g.out_y !== w.out_y) report("out_y", g.out_y, w.out_y);
                if (g.out_z !== w.out_z) report("out_z", g.out_z, w.out_z);
                if (g.status !== w.status) report("status", g.status, w.status);
            end
        end
    end

    // Drop valid once, if still held, before a gap or after the last beat sent.
    task automatic drop_valid();
        if (in_held) begin
            in_ch.valid <= 1'b0;
            in_held = 0;
        end
    endtask

    // Send one beat, sometimes with a random gap in front of it.
    task automatic send_beat(input t_in b);
        int gap;
        if ($urandom_range(0, 2) == 0) begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 30)
                                                : $urandom_range(1, 3);
            drop_valid();
            repeat (gap) @(posedge i_clk);
        end
        in_ch.data  <= b;
        in_ch.valid <= 1'b1;
        in_held = 1;
        do @(posedge i_clk); while (!in_ch.ready);
        skin_predict(b);
    endtask

    task automatic drain();
        drop_valid();
        while (expected_q.size() != 0) @(posedge i_clk);
        // let a trailing non-result beat finish in the back end
        repeat (60) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx[0], 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_BLEND_MODE) mode_local = val[0];
        else joints_used = val[6:0] < NJ ? val[6:0] : NJ;
        @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return -32'sh8000_0000;
            2: return $signed($urandom_range(0, 131072)) - 65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in blank_beat();
        t_in b;
        b = '0;
        b.matrix_word = $urandom;
        b.weight = 17'($urandom);
        b.vec_x = $urandom; b.vec_y = $urandom;
        b.vec_z = $urandom; b.vec_w = $urandom;
        return b;
    endfunction

    task automatic write_word(input int j, input int e, input logic signed [31:0] v);
        t_in b;
        b = blank_beat();
        b.cmd = CMD_WRITE; b.joint = 6'(j); b.elem = 4'(e); b.matrix_word = v;
        send_beat(b);
    endtask

    task automatic weight_beat(input int j, input logic [16:0] w, input bit lst);
        t_in b;
        b = blank_beat();
        b.cmd = CMD_WEIGHT; b.joint = 6'(j); b.weight = w; b.last = lst;
        b.vec_x = rnd_word(); b.vec_y = rnd_word();
        b.vec_z = rnd_word(); b.vec_w = rnd_word();
        b.elem = 4'($urandom_range(0, 15));
        send_beat(b);
    endtask

    // Fill every joint so no weight beat reads an unwritten word.
    task automatic test_fill_store();
        for (int j = 0; j < NJ; j++)
            for (int e = 0; e < 12; e++)
                write_word(j, e, (e % 5 == 0) ? 32'sh0001_0000 : rnd_word());
    endtask

    task automatic test_directed();
        t_in b;
        // ignored writes: elem out of range
        b = blank_beat(); b.cmd = CMD_WRITE; b.elem = 4'd15; b.joint = 6'd63;
        send_beat(b);
        b.elem = 4'd12; send_beat(b);
        weight_beat(0, 17'd65536, 1);
        weight_beat(63, 17'h1FFFF, 1);          // oversized weight
        weight_beat(5, 17'd0, 0);
        weight_beat(6, 17'd32768, 1);
        write_word(7, 0, 32'sh7FFF_FFFF);        // saturating entry
        weight_beat(7, 17'h1FFFF, 0);
        weight_beat(7, 17'h1FFFF, 1);
        drain();
        apb_write(REG_JOINT_COUNT, 32'd1);
        weight_beat(0, 17'd65536, 0);
        weight_beat(1, 17'd65536, 1);            // out of range
        drain();
        apb_write(REG_JOINT_COUNT, 32'd0);      // every joint out of range
        weight_beat(0, 17'd100, 1);
        drain();
        apb_write(REG_JOINT_COUNT, 32'h7F);
        apb_write(REG_BLEND_MODE, 32'd1);
        weight_beat(0, 17'd0, 0);
        weight_beat(7, 17'd1, 0);
        weight_beat(63, 17'd65536, 1);
        drain();
    endtask

    task automatic test_random(input int n, input int jc, input bit loc);
        int sent;
        int len;
        apb_write(REG_BLEND_MODE, {31'd0, loc});
        apb_write(REG_JOINT_COUNT, jc);
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 7) == 0) begin
                write_word($urandom_range(0, NJ-1), $urandom_range(0, 15), rnd_word());
                sent++;
            end else begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    weight_beat($urandom_range(0, NJ-1),
                                ($urandom_range(0, 9) == 0) ? 17'($urandom)
                                                            : 17'($urandom_range(0, 65536)),
                                i == len-1);
                    sent++;
                end
            end
            if (sent % 200 < 4 && $urandom_range(0, 1) == 0) begin
                // hold off until all results are in
                drop_valid();
                while (expected_q.size() != 0) @(posedge i_clk);
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_ch.valid = 1'b0; in_ch.data = '0;
        in_held = 0;
        fail_count = 0; cycle_count = 0;
        vert_open_next = 1; vert_err = 0; vert_sat = 0;
        mode_local = 0; joints_used = NJ;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_store();
        test_directed();
        test_random(150, 64, 0);
        test_random(150, 64, 1);
        test_random(60, 40, 0);
        test_random(60, 1, 1);
        test_random(45, 100, 0);
        drain();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
